FILE: rtl/tbld_pkg.sv
// shared types, character constants and keyword tables for the line decoder
package tbld_pkg;

	// line number and its decimal form
	localparam int NUM_W   = 16;
	localparam int DIGITS  = 5;
	localparam int BCD_W   = DIGITS * 4;

	// token and character codes
	localparam logic [7:0] BYTE_MARK  = 8'hFF;
	localparam logic [7:0] BYTE_EOL   = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [3:0] TOKEN_LEN  = 4'd12;

	// status from the binary to decimal unit
	typedef struct packed {
		logic                            done;
		logic [DIGITS-1:0][3:0]          digits;
	} b2d_stat_t;

	// keyword text, right-aligned, first character in the highest used byte
	function automatic logic [63:0] kw_text(input logic [7:0] code);
		logic [63:0] t;
		t = '0;
		case (code)
			8'h81: t = 64'("END");
			8'h82: t = 64'("FOR");
			8'h83: t = 64'("NEXT");
			8'h84: t = 64'("DATA");
			8'h85: t = 64'("INPUT");
			8'h86: t = 64'("DIM");
			8'h87: t = 64'("READ");
			8'h88: t = 64'("LET");
			8'h89: t = 64'("GOTO");
			8'h8A: t = 64'("RUN");
			8'h8B: t = 64'("IF");
			8'h8C: t = 64'("RESTORE");
			8'h8D: t = 64'("GOSUB");
			8'h8E: t = 64'("RETURN");
			8'h8F: t = 64'("REM");
			8'h91: t = 64'("PRINT");
			8'h92: t = 64'("ON");
			8'h96: t = 64'("DEF");
			8'h97: t = 64'("POKE");
			8'h98: t = 64'("PRINT#");
			8'h99: t = 64'("SECURE");
			8'h9A: t = 64'("CLS");
			8'h9B: t = 64'("WIDTH");
			8'h9C: t = 64'("ELSE");
			8'h9D: t = 64'("TRON");
			8'h9E: t = 64'("TROFF");
			8'h9F: t = 64'("SWAP");
			8'hA0: t = 64'("ERASE");
			8'hA1: t = 64'("EDIT");
			8'hA2: t = 64'("ERROR");
			8'hA3: t = 64'("RESUME");
			8'hA4: t = 64'("PLAY");
			8'hA5: t = 64'("ON/ERROR");
			8'hA6: t = 64'("LIST");
			8'hA7: t = 64'("NEW");
			8'hA8: t = 64'("ON/KEY");
			8'hA9: t = 64'("ON/PLAY");
			8'hAA: t = 64'("ON/TIMER");
			8'hAB: t = 64'("OPTION");
			8'hAC: t = 64'("ENVIRON");
			8'hAD: t = 64'("SYSTEM");
			8'hAE: t = 64'("KEY");
			8'hAF: t = 64'("SHELL");
			8'hB0: t = 64'("CLOSE");
			8'hB1: t = 64'("LOAD");
			8'hB2: t = 64'("MERGE");
			8'hB3: t = 64'("SAVE");
			8'hB4: t = 64'("COLOR");
			8'hB7: t = 64'("OPEN");
			8'hB8: t = 64'("FIELD");
			8'hB9: t = 64'("GET");
			8'hBA: t = 64'("PUT");
			8'hBB: t = 64'("SEEK");
			8'hBC: t = 64'("FILES");
			8'hBD: t = 64'("KILL");
			8'hBE: t = 64'("CHDIR");
			8'hBF: t = 64'("MKDIR");
			8'hC0: t = 64'("RMDIR");
			8'hC1: t = 64'("NAME");
			8'hC2: t = 64'("LINE");
			8'hC3: t = 64'("CIRCLE");
			8'hC4: t = 64'("PSET");
			8'hC5: t = 64'("PRESET");
			8'hC6: t = 64'("SCREEN");
			8'hC7: t = 64'("PAINT");
			8'hC8: t = 64'("SOUND");
			8'hCC: t = 64'("USING");
			8'hCD: t = 64'("THEN");
			8'hCE: t = 64'("TO");
			8'hCF: t = 64'("STEP");
			default: t = '0;
		endcase
		return t;
	endfunction

	// keyword length, zero when the code has no keyword
	function automatic logic [3:0] kw_len(input logic [63:0] t);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (t[i*8 +: 8] != 8'h00) n = 4'(i + 1);
		end
		return n;
	endfunction

	// uppercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) c = 8'h30 + {4'h0, d};
		else c = 8'h37 + {4'h0, d};
		return c;
	endfunction

	// characters of the unmapped token text
	function automatic logic [7:0] tok_char(input logic [3:0] idx, input logic [7:0] code);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "[";
			4'd1:    c = "T";
			4'd2:    c = "O";
			4'd3:    c = "K";
			4'd4:    c = "E";
			4'd5:    c = "N";
			4'd6:    c = ":";
			4'd7:    c = "0";
			4'd8:    c = "x";
			4'd9:    c = hex_char(code[7:4]);
			4'd10:   c = hex_char(code[3:0]);
			default: c = "]";
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/tbld_b2d.sv
// binary to decimal unit: one shift-and-add-three step per cycle
module tbld_b2d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tbld_pkg::NUM_W-1:0]    value,
	output tbld_pkg::b2d_stat_t           stat
);

	logic [tbld_pkg::NUM_W-1:0]           bin_q;
	logic [tbld_pkg::DIGITS-1:0][3:0]     bcd_q;
	logic [3:0]                           cnt_q;
	logic                                 busy_q;
	logic                                 done_q;
	logic [tbld_pkg::DIGITS-1:0][3:0]     adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < tbld_pkg::DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 4'd15);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) busy_q <= 1'b0;
			end
		end
	end

	// shift register of binary and decimal digits
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			{bcd_q, bin_q} <= {adj, bin_q} << 1;
		end
	end

	assign stat.done   = done_q;
	assign stat.digits = bcd_q;

endmodule

FILE: rtl/tokenized_basic_line_decoder.sv
// top level: tokenized program bytes in, listing characters out
//
//  channel  handshake            payload
//  in       in_valid, in_stall   byte_in[7:0], last_byte
//  out      out_valid, out_stall char_out[7:0], run_end, program_end
//
// a header byte or an ignored byte gives no character
// a body byte gives one or more characters (up to twelve)
// the high line number byte starts the shift-and-add-three unit, and once it is done
//   the number goes out as characters (up to seven)
// a stall on out holds the output register; in_stall is high while a request is worked on
// arst_n returns the decoder to the start of a file
module tokenized_basic_line_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] char_out,
	output logic       run_end,
	output logic       program_end
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CONV = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	typedef enum logic [6:0] {
		PH_START   = 7'b0000001,
		PH_LINK_LO = 7'b0000010,
		PH_LINK_HI = 7'b0000100,
		PH_NUM_LO  = 7'b0001000,
		PH_NUM_HI  = 7'b0010000,
		PH_BODY    = 7'b0100000,
		PH_DONE    = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		K_NUM,
		K_KW,
		K_TOK,
		K_CHR
	} kind_t;

	state_t                     state_q;
	phase_t                     phase_q;
	phase_t                     ph_nxt;
	logic [7:0]                 hold_q;
	logic [7:0]                 hold_nxt;
	kind_t                      kind_q;
	kind_t                      kind_nxt;
	logic [3:0]                 cnt_q;
	logic [3:0]                 cnt_nxt;
	logic [3:0]                 idx_q;
	logic [7:0]                 byte_q;
	logic [7:0]                 byte_nxt;
	logic                       last_q;
	logic                       start_num;
	logic                       start_emit;
	logic                       acc;
	logic [3:0]                 in_kw_n;
	logic                       out_valid_q;
	logic [7:0]                 char_q;
	logic                       run_end_q;
	logic                       prog_end_q;
	tbld_pkg::b2d_stat_t        b2d_st;
	logic [2:0]                 lead;
	logic [2:0]                 ndig;
	logic [2:0]                 pos;
	logic [2:0]                 dsel;
	logic [7:0][7:0]            kw_b;
	logic [3:0]                 kw_n;
	logic [2:0]                 ksel;
	logic [7:0]                 ch;
	logic                       slot_free;
	logic                       is_final;

	assign acc      = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// decimal conversion of the line number
	tbld_b2d u_b2d (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc && start_num),
		.value  ({byte_in, hold_q}),
		.stat   (b2d_st)
	);

	// decode of the incoming byte against the line phase
	assign in_kw_n = tbld_pkg::kw_len(tbld_pkg::kw_text(byte_in));

	always_comb begin
		ph_nxt     = phase_q;
		hold_nxt   = hold_q;
		start_num  = 1'b0;
		start_emit = 1'b0;
		kind_nxt   = K_CHR;
		cnt_nxt    = 4'd1;
		byte_nxt   = byte_in;
		case (phase_q)
			PH_START: begin
				if (byte_in == tbld_pkg::BYTE_MARK) begin
					ph_nxt = PH_LINK_LO;
				end else begin
					hold_nxt = byte_in;
					ph_nxt   = PH_LINK_HI;
				end
			end
			PH_LINK_LO: begin
				hold_nxt = byte_in;
				ph_nxt   = PH_LINK_HI;
			end
			PH_LINK_HI: begin
				ph_nxt = ({byte_in, hold_q} == 16'h0000) ? PH_DONE : PH_NUM_LO;
			end
			PH_NUM_LO: begin
				hold_nxt = byte_in;
				ph_nxt   = PH_NUM_HI;
			end
			PH_NUM_HI: begin
				start_num = 1'b1;
				kind_nxt  = K_NUM;
				ph_nxt    = PH_BODY;
			end
			PH_BODY: begin
				start_emit = 1'b1;
				if (byte_in == tbld_pkg::BYTE_EOL) begin
					byte_nxt = tbld_pkg::CH_NL;
					ph_nxt   = PH_LINK_LO;
				end else if (byte_in[7]) begin
					if (in_kw_n != 4'd0) begin
						kind_nxt = K_KW;
						cnt_nxt  = in_kw_n + {3'b000, last_byte};
					end else begin
						kind_nxt = K_TOK;
						cnt_nxt  = tbld_pkg::TOKEN_LEN;
					end
				end else begin
					cnt_nxt = 4'd1 + {3'b000, last_byte};
				end
			end
			PH_DONE: begin
				ph_nxt = PH_DONE;
			end
			default: begin
				ph_nxt = PH_DONE;
			end
		endcase
		if (last_byte) begin
			ph_nxt   = PH_START;
			hold_nxt = '0;
		end
	end

	// leading zero suppression of the converted number
	always_comb begin
		if (b2d_st.digits[4] != 4'd0)      lead = 3'd0;
		else if (b2d_st.digits[3] != 4'd0) lead = 3'd1;
		else if (b2d_st.digits[2] != 4'd0) lead = 3'd2;
		else if (b2d_st.digits[1] != 4'd0) lead = 3'd3;
		else                               lead = 3'd4;
	end

	assign ndig = 3'd5 - lead;
	assign pos  = idx_q[2:0] + lead;
	assign dsel = 3'd4 - pos;

	// keyword rom read for the held token
	assign kw_b = tbld_pkg::kw_text(byte_q);
	assign kw_n = tbld_pkg::kw_len(kw_b);
	assign ksel = 3'(kw_n - 4'd1 - idx_q);

	// character at the current position of the run
	always_comb begin
		case (kind_q)
			K_NUM: begin
				if (idx_q < {1'b0, ndig})
					ch = tbld_pkg::CH_ZERO + {4'h0, b2d_st.digits[dsel]};
				else if (idx_q == {1'b0, ndig})
					ch = tbld_pkg::CH_SPACE;
				else
					ch = tbld_pkg::CH_NL;
			end
			K_KW:    ch = (idx_q < kw_n) ? kw_b[ksel] : tbld_pkg::CH_NL;
			K_TOK:   ch = tbld_pkg::tok_char(idx_q, byte_q);
			K_CHR:   ch = (idx_q == 4'd0) ? byte_q : tbld_pkg::CH_NL;
			default: ch = tbld_pkg::CH_NL;
		endcase
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign is_final  = (idx_q == cnt_q - 4'd1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_START;
			hold_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= ph_nxt;
						hold_q  <= hold_nxt;
						if (start_num) state_q <= S_CONV;
						else if (start_emit) state_q <= S_EMIT;
					end
				end
				S_CONV: begin
					if (b2d_st.done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free && is_final) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// run descriptor
	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= kind_nxt;
			cnt_q  <= cnt_nxt;
			byte_q <= byte_nxt;
			last_q <= last_byte;
			idx_q  <= '0;
		end else if (state_q == S_CONV && b2d_st.done) begin
			cnt_q <= {1'b0, ndig} + 4'd1 + {3'b000, last_q};
		end else if (state_q == S_EMIT && slot_free) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && slot_free) begin
			char_q     <= ch;
			run_end_q  <= is_final;
			prog_end_q <= is_final && last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign char_out    = char_q;
	assign run_end     = run_end_q;
	assign program_end = prog_end_q;

	// checks
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		b2d_st.done |-> state_q == S_CONV)
		else $error("conversion finished outside its wait state");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> (idx_q < cnt_q) && (cnt_q <= tbld_pkg::TOKEN_LEN))
		else $error("character index beyond the run");

	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && program_end |-> run_end)
		else $error("end of file flagged without end of run");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> phase_q == PH_START)
		else $error("final byte did not rearm the decoder");

endmodule
